/* rtl/core/cpcr_pkg.sv */
// shared constants and types of the circle pair collision core
`default_nettype none

package cpcr_pkg;

  localparam int POS_W = 20;
  localparam int VEL_W = 16;
  localparam int RAD_W = 8;
  // center line components are halved until below 2**N_LOG
  localparam int N_LOG = 20;
  // quotient bits of the velocity divider, enough for a velocity difference
  localparam int QW    = VEL_W + 2;

  typedef struct packed {
    logic signed [POS_W-1:0] pxa;
    logic signed [POS_W-1:0] pya;
    logic signed [POS_W-1:0] pxb;
    logic signed [POS_W-1:0] pyb;
    logic signed [VEL_W-1:0] vxa;
    logic signed [VEL_W-1:0] vya;
    logic signed [VEL_W-1:0] vxb;
    logic signed [VEL_W-1:0] vyb;
  } pair_t;

endpackage

`default_nettype wire

/* rtl/core/circle_pair_collision_resolve_core.sv */
// circle pair collision core: overlap push-apart and equal-mass velocity exchange
// throughput: one pair per cycle; busy_o stays low and the pipeline never stalls
// latency is set by the square root (one root bit per stage) and the two
//   restoring dividers (one quotient bit per stage) that lie in series
// reset clears only the valid pipeline; no result is lost since the receiver cannot stall
`default_nettype none

module circle_pair_collision_resolve_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic signed [cpcr_pkg::POS_W-1:0] pos_x_a_i,
  input  wire logic signed [cpcr_pkg::POS_W-1:0] pos_y_a_i,
  input  wire logic        [cpcr_pkg::RAD_W-1:0] radius_a_i,
  input  wire logic signed [cpcr_pkg::VEL_W-1:0] vel_x_a_i,
  input  wire logic signed [cpcr_pkg::VEL_W-1:0] vel_y_a_i,
  input  wire logic signed [cpcr_pkg::POS_W-1:0] pos_x_b_i,
  input  wire logic signed [cpcr_pkg::POS_W-1:0] pos_y_b_i,
  input  wire logic        [cpcr_pkg::RAD_W-1:0] radius_b_i,
  input  wire logic signed [cpcr_pkg::VEL_W-1:0] vel_x_b_i,
  input  wire logic signed [cpcr_pkg::VEL_W-1:0] vel_y_b_i,
  output logic             done_o,
  output logic signed [cpcr_pkg::POS_W-1:0] new_pos_x_a_o,
  output logic signed [cpcr_pkg::POS_W-1:0] new_pos_y_a_o,
  output logic signed [cpcr_pkg::VEL_W-1:0] new_vel_x_a_o,
  output logic signed [cpcr_pkg::VEL_W-1:0] new_vel_y_a_o,
  output logic signed [cpcr_pkg::POS_W-1:0] new_pos_x_b_o,
  output logic signed [cpcr_pkg::POS_W-1:0] new_pos_y_b_o,
  output logic signed [cpcr_pkg::VEL_W-1:0] new_vel_x_b_o,
  output logic signed [cpcr_pkg::VEL_W-1:0] new_vel_y_b_o,
  output logic             hit_o,
  output logic             coincident_o
);

  localparam int POS_W = cpcr_pkg::POS_W;
  localparam int VEL_W = cpcr_pkg::VEL_W;
  localparam int RAD_W = cpcr_pkg::RAD_W;
  localparam int N_LOG = cpcr_pkg::N_LOG;
  localparam int QW    = cpcr_pkg::QW;

  localparam int SW    = RAD_W + 1 + FRAC_BITS;
  localparam int DW    = ((POS_W > RAD_W + FRAC_BITS) ? POS_W : RAD_W + FRAC_BITS) + 2;
  localparam int SQW   = 2 * DW - 2;
  localparam int D2W   = 2 * DW - 1;
  localparam int VDW   = VEL_W + 1;
  localparam int NW    = SW + 3;
  localparam int NMW   = NW - 1;
  localparam int KMAX  = (NMW > N_LOG) ? NMW - N_LOG : 0;
  localparam int KW    = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
  localparam int NSW   = (NMW > N_LOG) ? N_LOG + 1 : NW;
  localparam int NMAGW = NSW - 1;
  localparam int NNW   = 2 * NMAGW + 1;
  localparam int DFW   = VDW + NSW + 1;
  localparam int LO    = DFW / 2;
  localparam int HI    = DFW - LO;
  localparam int PW    = NMAGW + DFW;
  localparam int RW    = PW + 1;
  localparam int PSW   = ((POS_W > SW + 1) ? POS_W : SW + 1) + 2;
  localparam int VSW   = QW + 3;
  localparam int LAT   = 2 * SW + QW + 14;

  typedef struct packed {
    logic                  hit;
    logic                  coinc;
    cpcr_pkg::pair_t       p;
    logic signed [SW:0]    dx;
    logic signed [SW:0]    dy;
    logic [SW-1:0]         sum;
    logic signed [VDW-1:0] vdx;
    logic signed [VDW-1:0] vdy;
  } meta_t;

  typedef struct packed {
    logic                  hit;
    logic                  coinc;
    cpcr_pkg::pair_t       p;
    logic signed [VDW-1:0] vdx;
    logic signed [VDW-1:0] vdy;
  } tail_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PSW-1:0] v);
    logic [PSW-POS_W:0] top;
    top = v[PSW-1:POS_W-1];
    if (top == '0 || top == '1) begin
      return v[POS_W-1:0];
    end
    return v[PSW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VSW-1:0] v);
    logic [VSW-VEL_W:0] top;
    top = v[VSW-1:VEL_W-1];
    if (top == '0 || top == '1) begin
      return v[VEL_W-1:0];
    end
    return v[VSW-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

  // ---------------------------------------------------------------------------
  // valid pipeline
  // ---------------------------------------------------------------------------
  logic           accept;
  logic [LAT-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign done_o = vld_q[LAT-1];

  // ---------------------------------------------------------------------------
  // stage 1: center differences plus the radius difference, radius sum, velocity differences
  // ---------------------------------------------------------------------------
  cpcr_pkg::pair_t       s1_p_q;
  logic signed [DW-1:0]  s1_dx_q, s1_dy_q, rd_d;
  logic [SW-1:0]         s1_sum_q;
  logic signed [VDW-1:0] s1_vdx_q, s1_vdy_q;

  assign rd_d = DW'($signed({1'b0, radius_b_i})) - DW'($signed({1'b0, radius_a_i}));

  always_ff @(posedge clk_i) begin
    s1_p_q   <= '{pxa: pos_x_a_i, pya: pos_y_a_i, pxb: pos_x_b_i, pyb: pos_y_b_i,
                  vxa: vel_x_a_i, vya: vel_y_a_i, vxb: vel_x_b_i, vyb: vel_y_b_i};
    s1_dx_q  <= DW'(pos_x_b_i) - DW'(pos_x_a_i) + (rd_d <<< FRAC_BITS);
    s1_dy_q  <= DW'(pos_y_b_i) - DW'(pos_y_a_i) + (rd_d <<< FRAC_BITS);
    s1_sum_q <= (SW'(radius_a_i) + SW'(radius_b_i)) << FRAC_BITS;
    s1_vdx_q <= VDW'(vel_x_b_i) - VDW'(vel_x_a_i);
    s1_vdy_q <= VDW'(vel_y_b_i) - VDW'(vel_y_a_i);
  end

  // ---------------------------------------------------------------------------
  // stage 2: squares
  // ---------------------------------------------------------------------------
  cpcr_pkg::pair_t       s2_p_q;
  logic signed [DW-1:0]  s2_dx_q, s2_dy_q;
  logic [SW-1:0]         s2_sum_q;
  logic signed [VDW-1:0] s2_vdx_q, s2_vdy_q;
  logic [SQW-1:0]        s2_dxx_q, s2_dyy_q;
  logic [2*SW-1:0]       s2_ss_q;
  logic [DW-2:0]         s1_adx_d, s1_ady_d;

  assign s1_adx_d = (DW-1)'(s1_dx_q[DW-1] ? -s1_dx_q : s1_dx_q);
  assign s1_ady_d = (DW-1)'(s1_dy_q[DW-1] ? -s1_dy_q : s1_dy_q);

  always_ff @(posedge clk_i) begin
    s2_p_q   <= s1_p_q;
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_sum_q <= s1_sum_q;
    s2_vdx_q <= s1_vdx_q;
    s2_vdy_q <= s1_vdy_q;
    s2_dxx_q <= s1_adx_d * s1_adx_d;
    s2_dyy_q <= s1_ady_d * s1_ady_d;
    s2_ss_q  <= s1_sum_q * s1_sum_q;
  end

  // ---------------------------------------------------------------------------
  // stage 3: squared distance
  // ---------------------------------------------------------------------------
  cpcr_pkg::pair_t       s3_p_q;
  logic signed [DW-1:0]  s3_dx_q, s3_dy_q;
  logic [SW-1:0]         s3_sum_q;
  logic signed [VDW-1:0] s3_vdx_q, s3_vdy_q;
  logic [D2W-1:0]        s3_d2_q;
  logic [2*SW-1:0]       s3_ss_q;

  always_ff @(posedge clk_i) begin
    s3_p_q   <= s2_p_q;
    s3_dx_q  <= s2_dx_q;
    s3_dy_q  <= s2_dy_q;
    s3_sum_q <= s2_sum_q;
    s3_vdx_q <= s2_vdx_q;
    s3_vdy_q <= s2_vdy_q;
    s3_d2_q  <= D2W'(s2_dxx_q) + D2W'(s2_dyy_q);
    s3_ss_q  <= s2_ss_q;
  end

  // ---------------------------------------------------------------------------
  // stage 4 and square root: one root bit per stage
  // ---------------------------------------------------------------------------
  meta_t           sq_m_q    [SW+1];
  logic [2*SW-1:0] sq_rem_q  [SW+1];
  logic [SW-1:0]   sq_root_q [SW+1];
  logic            s3_coinc_d, s3_hit_d;

  assign s3_coinc_d = (s3_d2_q == '0);
  assign s3_hit_d   = !s3_coinc_d && (s3_d2_q <= D2W'(s3_ss_q));

  always_ff @(posedge clk_i) begin
    sq_m_q[0]    <= '{hit: s3_hit_d, coinc: s3_coinc_d, p: s3_p_q,
                      dx: s3_dx_q[SW:0], dy: s3_dy_q[SW:0], sum: s3_sum_q,
                      vdx: s3_vdx_q, vdy: s3_vdy_q};
    // only a hit needs the root, and then the distance fits 2*SW bits
    sq_rem_q[0]  <= s3_d2_q[2*SW-1:0];
    sq_root_q[0] <= '0;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int J = SW - 1 - k;
    logic [2*SW:0]   trial;
    logic [2*SW-1:0] rem_d;
    logic [SW-1:0]   root_d;

    always_comb begin
      trial  = ((2*SW+1)'(sq_root_q[k]) << (J + 1)) + ((2*SW+1)'(1) << (2 * J));
      rem_d  = sq_rem_q[k];
      root_d = sq_root_q[k];
      if ({1'b0, sq_rem_q[k]} >= trial) begin
        rem_d     = sq_rem_q[k] - trial[2*SW-1:0];
        root_d[J] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_m_q[k+1]    <= sq_m_q[k];
      sq_rem_q[k+1]  <= rem_d;
      sq_root_q[k+1] <= root_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 5 to 7: overlap, push numerator, divider setup
  // ---------------------------------------------------------------------------
  meta_t           s5_m_q, s6_m_q;
  logic [SW-1:0]   s5_h_q, s5_dist_q, s6_dist_q;
  logic [2*SW-1:0] s6_px_q, s6_py_q;
  logic [SW:0]     s5_adx_d, s5_ady_d;

  always_ff @(posedge clk_i) begin
    s5_m_q    <= sq_m_q[SW];
    s5_dist_q <= sq_root_q[SW];
    s5_h_q    <= sq_m_q[SW].sum - sq_root_q[SW];
  end

  assign s5_adx_d = s5_m_q.dx[SW] ? -s5_m_q.dx : s5_m_q.dx;
  assign s5_ady_d = s5_m_q.dy[SW] ? -s5_m_q.dy : s5_m_q.dy;

  always_ff @(posedge clk_i) begin
    s6_m_q    <= s5_m_q;
    s6_dist_q <= s5_dist_q;
    s6_px_q   <= s5_adx_d[SW-1:0] * s5_h_q;
    s6_py_q   <= s5_ady_d[SW-1:0] * s5_h_q;
  end

  meta_t         dm_m_q   [SW+1];
  logic [2*SW:0] dm_rx_q  [SW+1];
  logic [2*SW:0] dm_ry_q  [SW+1];
  logic [SW:0]   dm_den_q [SW+1];
  logic [SW-1:0] dm_qx_q  [SW+1];
  logic [SW-1:0] dm_qy_q  [SW+1];

  // round half away from zero: add half the divisor (the distance) first
  always_ff @(posedge clk_i) begin
    dm_m_q[0]   <= s6_m_q;
    dm_rx_q[0]  <= (2*SW+1)'(s6_px_q) + (2*SW+1)'(s6_dist_q);
    dm_ry_q[0]  <= (2*SW+1)'(s6_py_q) + (2*SW+1)'(s6_dist_q);
    dm_den_q[0] <= (SW+1)'(s6_dist_q) << 1;
    dm_qx_q[0]  <= '0;
    dm_qy_q[0]  <= '0;
  end

  for (genvar k = 0; k < SW; k++) begin : g_push_div
    localparam int I = SW - 1 - k;
    logic [2*SW:0]  trial;
    logic [2*SW:0]  rx_d, ry_d;
    logic [SW-1:0]  qx_d, qy_d;

    always_comb begin
      trial = (2*SW+1)'(dm_den_q[k]) << I;
      rx_d  = dm_rx_q[k];
      ry_d  = dm_ry_q[k];
      qx_d  = dm_qx_q[k];
      qy_d  = dm_qy_q[k];
      if (dm_rx_q[k] >= trial) begin
        rx_d    = dm_rx_q[k] - trial;
        qx_d[I] = 1'b1;
      end
      if (dm_ry_q[k] >= trial) begin
        ry_d    = dm_ry_q[k] - trial;
        qy_d[I] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      dm_m_q[k+1]   <= dm_m_q[k];
      dm_rx_q[k+1]  <= rx_d;
      dm_ry_q[k+1]  <= ry_d;
      dm_den_q[k+1] <= dm_den_q[k];
      dm_qx_q[k+1]  <= qx_d;
      dm_qy_q[k+1]  <= qy_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: new positions and new center line
  // ---------------------------------------------------------------------------
  meta_t                m8;
  logic signed [SW:0]   mxs_d, mys_d, mx_d, my_d;
  cpcr_pkg::pair_t      p8_d;
  tail_t                s8_t_q;
  logic signed [NW-1:0] s8_nx_q, s8_ny_q;

  assign m8    = dm_m_q[SW];
  assign mxs_d = $signed({1'b0, dm_qx_q[SW]});
  assign mys_d = $signed({1'b0, dm_qy_q[SW]});
  assign mx_d  = m8.dx[SW] ? -mxs_d : mxs_d;
  assign my_d  = m8.dy[SW] ? -mys_d : mys_d;

  always_comb begin
    p8_d = m8.p;
    if (m8.hit) begin
      p8_d.pxa = sat_pos(PSW'(m8.p.pxa) - PSW'(mx_d));
      p8_d.pya = sat_pos(PSW'(m8.p.pya) - PSW'(my_d));
      p8_d.pxb = sat_pos(PSW'(m8.p.pxb) + PSW'(mx_d));
      p8_d.pyb = sat_pos(PSW'(m8.p.pyb) + PSW'(my_d));
    end
  end

  always_ff @(posedge clk_i) begin
    s8_t_q  <= '{hit: m8.hit, coinc: m8.coinc, p: p8_d, vdx: m8.vdx, vdy: m8.vdy};
    s8_nx_q <= NW'(m8.dx) + (NW'(mx_d) <<< 1);
    s8_ny_q <= NW'(m8.dy) + (NW'(my_d) <<< 1);
  end

  // ---------------------------------------------------------------------------
  // stage 9: scale the center line below the product limit
  // ---------------------------------------------------------------------------
  logic [NMW-1:0]        anx_d, any_d, amax_d;
  logic [KW-1:0]         ksel_d;
  logic [NMAGW-1:0]      snx_d, sny_d;
  tail_t                 s9_t_q;
  logic signed [NSW-1:0] s9_nx_q, s9_ny_q;

  assign anx_d  = NMW'(s8_nx_q[NW-1] ? -s8_nx_q : s8_nx_q);
  assign any_d  = NMW'(s8_ny_q[NW-1] ? -s8_ny_q : s8_ny_q);
  assign amax_d = (anx_d > any_d) ? anx_d : any_d;

  // repeated halving toward zero equals one shift of the magnitude
  always_comb begin
    ksel_d = '0;
    for (int k = KMAX; k >= 0; k--) begin
      if ((amax_d >> (k + N_LOG)) == '0) begin
        ksel_d = KW'(k);
      end
    end
  end

  assign snx_d = NMAGW'(anx_d >> ksel_d);
  assign sny_d = NMAGW'(any_d >> ksel_d);

  always_ff @(posedge clk_i) begin
    s9_t_q  <= s8_t_q;
    s9_nx_q <= s8_nx_q[NW-1] ? -NSW'(snx_d) : NSW'(snx_d);
    s9_ny_q <= s8_ny_q[NW-1] ? -NSW'(sny_d) : NSW'(sny_d);
  end

  // ---------------------------------------------------------------------------
  // stages 10 to 13: dot products and the velocity divider setup
  // ---------------------------------------------------------------------------
  logic [NMAGW-1:0]          s9_anx_d, s9_any_d;
  tail_t                     s10_t_q, s11_t_q, s12_t_q;
  logic signed [NSW-1:0]     s10_nx_q, s10_ny_q, s11_nx_q, s11_ny_q;
  logic [2*NMAGW-1:0]        s10_nxx_q, s10_nyy_q;
  logic signed [VDW+NSW-1:0] s10_pdx_q, s10_pdy_q;
  logic [NNW-1:0]            s11_nn_q, s12_nn_q;
  logic signed [DFW-1:0]     s11_diff_q;
  logic [NMAGW-1:0]          s11_anx_d, s11_any_d;
  logic [DFW-1:0]            s11_ad_d;
  logic [NMAGW+LO-1:0]       s12_plx_q, s12_ply_q;
  logic [NMAGW+HI-1:0]       s12_phx_q, s12_phy_q;
  logic                      s12_sx_q, s12_sy_q, s12_nz_q;

  assign s9_anx_d = NMAGW'(s9_nx_q[NSW-1] ? -s9_nx_q : s9_nx_q);
  assign s9_any_d = NMAGW'(s9_ny_q[NSW-1] ? -s9_ny_q : s9_ny_q);

  always_ff @(posedge clk_i) begin
    s10_t_q   <= s9_t_q;
    s10_nx_q  <= s9_nx_q;
    s10_ny_q  <= s9_ny_q;
    s10_nxx_q <= s9_anx_d * s9_anx_d;
    s10_nyy_q <= s9_any_d * s9_any_d;
    s10_pdx_q <= s9_t_q.vdx * s9_nx_q;
    s10_pdy_q <= s9_t_q.vdy * s9_ny_q;
  end

  always_ff @(posedge clk_i) begin
    s11_t_q    <= s10_t_q;
    s11_nx_q   <= s10_nx_q;
    s11_ny_q   <= s10_ny_q;
    s11_nn_q   <= NNW'(s10_nxx_q) + NNW'(s10_nyy_q);
    s11_diff_q <= DFW'(s10_pdx_q) + DFW'(s10_pdy_q);
  end

  assign s11_anx_d = NMAGW'(s11_nx_q[NSW-1] ? -s11_nx_q : s11_nx_q);
  assign s11_any_d = NMAGW'(s11_ny_q[NSW-1] ? -s11_ny_q : s11_ny_q);
  assign s11_ad_d  = s11_diff_q[DFW-1] ? DFW'(-s11_diff_q) : DFW'(s11_diff_q);

  // wide product split in two halves of the difference
  always_ff @(posedge clk_i) begin
    s12_t_q   <= s11_t_q;
    s12_nn_q  <= s11_nn_q;
    s12_nz_q  <= (s11_nn_q != '0);
    s12_sx_q  <= s11_nx_q[NSW-1] ^ s11_diff_q[DFW-1];
    s12_sy_q  <= s11_ny_q[NSW-1] ^ s11_diff_q[DFW-1];
    s12_plx_q <= s11_anx_d * s11_ad_d[LO-1:0];
    s12_phx_q <= s11_anx_d * s11_ad_d[DFW-1:LO];
    s12_ply_q <= s11_any_d * s11_ad_d[LO-1:0];
    s12_phy_q <= s11_any_d * s11_ad_d[DFW-1:LO];
  end

  tail_t          dv_t_q  [QW+1];
  logic [RW-1:0]  dv_rx_q [QW+1];
  logic [RW-1:0]  dv_ry_q [QW+1];
  logic [NNW-1:0] dv_nn_q [QW+1];
  logic [QW-1:0]  dv_qx_q [QW+1];
  logic [QW-1:0]  dv_qy_q [QW+1];
  logic           dv_sx_q [QW+1];
  logic           dv_sy_q [QW+1];
  logic           dv_nz_q [QW+1];

  always_ff @(posedge clk_i) begin
    dv_t_q[0]  <= s12_t_q;
    dv_rx_q[0] <= (RW'(s12_phx_q) << LO) + RW'(s12_plx_q) + RW'(s12_nn_q >> 1);
    dv_ry_q[0] <= (RW'(s12_phy_q) << LO) + RW'(s12_ply_q) + RW'(s12_nn_q >> 1);
    dv_nn_q[0] <= s12_nn_q;
    dv_qx_q[0] <= '0;
    dv_qy_q[0] <= '0;
    dv_sx_q[0] <= s12_sx_q;
    dv_sy_q[0] <= s12_sy_q;
    dv_nz_q[0] <= s12_nz_q;
  end

  for (genvar k = 0; k < QW; k++) begin : g_vel_div
    localparam int I = QW - 1 - k;
    logic [RW-1:0] trial;
    logic [RW-1:0] rx_d, ry_d;
    logic [QW-1:0] qx_d, qy_d;

    always_comb begin
      trial = RW'(dv_nn_q[k]) << I;
      rx_d  = dv_rx_q[k];
      ry_d  = dv_ry_q[k];
      qx_d  = dv_qx_q[k];
      qy_d  = dv_qy_q[k];
      if (dv_rx_q[k] >= trial) begin
        rx_d    = dv_rx_q[k] - trial;
        qx_d[I] = 1'b1;
      end
      if (dv_ry_q[k] >= trial) begin
        ry_d    = dv_ry_q[k] - trial;
        qy_d[I] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_t_q[k+1]  <= dv_t_q[k];
      dv_rx_q[k+1] <= rx_d;
      dv_ry_q[k+1] <= ry_d;
      dv_nn_q[k+1] <= dv_nn_q[k];
      dv_qx_q[k+1] <= qx_d;
      dv_qy_q[k+1] <= qy_d;
      dv_sx_q[k+1] <= dv_sx_q[k];
      dv_sy_q[k+1] <= dv_sy_q[k];
      dv_nz_q[k+1] <= dv_nz_q[k];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 14: velocity exchange and output word
  // ---------------------------------------------------------------------------
  tail_t               t14;
  logic signed [QW:0]  dqx_d, dqy_d, dvx_d, dvy_d;
  cpcr_pkg::pair_t     p14_d, out_p_q;
  logic                out_hit_q, out_coinc_q;

  assign t14   = dv_t_q[QW];
  assign dqx_d = $signed({1'b0, dv_qx_q[QW]});
  assign dqy_d = $signed({1'b0, dv_qy_q[QW]});
  assign dvx_d = dv_sx_q[QW] ? -dqx_d : dqx_d;
  assign dvy_d = dv_sy_q[QW] ? -dqy_d : dqy_d;

  always_comb begin
    p14_d = t14.p;
    if (t14.hit && dv_nz_q[QW]) begin
      p14_d.vxa = sat_vel(VSW'(t14.p.vxa) + VSW'(dvx_d));
      p14_d.vya = sat_vel(VSW'(t14.p.vya) + VSW'(dvy_d));
      p14_d.vxb = sat_vel(VSW'(t14.p.vxb) - VSW'(dvx_d));
      p14_d.vyb = sat_vel(VSW'(t14.p.vyb) - VSW'(dvy_d));
    end
  end

  always_ff @(posedge clk_i) begin
    out_p_q     <= p14_d;
    out_hit_q   <= t14.hit;
    out_coinc_q <= t14.coinc;
  end

  assign new_pos_x_a_o = out_p_q.pxa;
  assign new_pos_y_a_o = out_p_q.pya;
  assign new_vel_x_a_o = out_p_q.vxa;
  assign new_vel_y_a_o = out_p_q.vya;
  assign new_pos_x_b_o = out_p_q.pxb;
  assign new_pos_y_b_o = out_p_q.pyb;
  assign new_vel_x_b_o = out_p_q.vxb;
  assign new_vel_y_b_o = out_p_q.vyb;
  assign hit_o         = out_hit_q;
  assign coincident_o  = out_coinc_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && coincident_o))
    else $error("hit and coincident both set");

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result word without a started pair");

  a_miss_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> new_pos_x_a_o == $past(pos_x_a_i, LAT) &&
                         new_pos_y_b_o == $past(pos_y_b_i, LAT))
    else $error("position changed without a hit");

  a_miss_keeps_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> new_vel_x_b_o == $past(vel_x_b_i, LAT) &&
                         new_vel_y_a_o == $past(vel_y_a_i, LAT))
    else $error("velocity changed without a hit");

endmodule

`default_nettype wire
